>>> rtl/gsfp_pkg.sv
// Package for the gas sensor frame parser: frame constants, register
// indexes, mode codes and the result struct. No dependencies.
package gsfp_pkg;

    localparam int FRAME_LENGTH  = 9;
    localparam int PAYLOAD_DEPTH = 6;
    localparam int POS_W         = 4;
    localparam int SLOT_W        = 3;
    localparam int PADDR_W       = 3;

    localparam logic [POS_W-1:0] POS_HUNT      = 4'd0;
    localparam logic [POS_W-1:0] POS_FIRST     = 4'd1;
    localparam logic [POS_W-1:0] POS_PAYLOAD0  = 4'd2;
    localparam logic [POS_W-1:0] POS_PAYLOAD_N = POS_W'(2 + PAYLOAD_DEPTH - 1);
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_LENGTH - 1);

    localparam logic [7:0] START_TAG_RESET = 8'hFF;

    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    typedef enum logic {
        MODE_UPLOAD = 1'b0,
        MODE_QUERY  = 1'b1
    } t_mode;

    typedef enum logic {
        REG_REPORT_MODE = 1'b0,
        REG_START_TAG   = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic        frame_status;
        logic [15:0] concentration_ppb;
        logic [15:0] concentration_ugm3;
    } t_result;

endpackage

>>> rtl/gsfp_cfg_regs.sv
// APB configuration registers: report_mode and start_tag.
// Depends on gsfp_pkg.
module gsfp_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gsfp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output gsfp_pkg::t_mode               o_mode,
    output logic [7:0]                    o_start_tag
);
    import gsfp_pkg::*;

    t_mode       r_mode;
    t_mode       n_mode;
    logic [7:0]  r_tag;
    logic [7:0]  n_tag;
    t_reg_idx    w_idx;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_mode = r_mode;
        n_tag  = r_tag;
        if (w_wr) begin
            case (w_idx)
                REG_REPORT_MODE: n_mode = t_mode'(pwdata[0]);
                REG_START_TAG:   n_tag  = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_REPORT_MODE: prdata = {31'd0, r_mode};
            REG_START_TAG:   prdata = {24'd0, r_tag};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_UPLOAD;
            r_tag  <= START_TAG_RESET;
        end else begin
            r_mode <= n_mode;
            r_tag  <= n_tag;
        end
    end

    assign o_mode      = r_mode;
    assign o_start_tag = r_tag;

endmodule

>>> rtl/gsfp_frame_parser.sv
// Frame parser: hunt for start tag, byte position counter, running sum,
// payload byte registers and checksum/field selection. Depends on gsfp_pkg.
module gsfp_frame_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte,
    input  gsfp_pkg::t_mode       i_mode,
    input  logic [7:0]            i_start_tag,
    output logic                  o_at_last,
    output logic                  o_res_valid,
    output gsfp_pkg::t_result     o_res
);
    import gsfp_pkg::*;

    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [7:0]        r_sum;
    logic [7:0]        n_sum;
    logic [7:0]        r_payload [PAYLOAD_DEPTH];
    logic [7:0]        w_expect;
    logic              w_hunt;
    logic              w_pl_wr;
    logic [SLOT_W-1:0] w_slot;

    assign w_hunt    = (r_pos == POS_HUNT) || (r_pos > POS_LAST);
    assign o_at_last = (r_pos == POS_LAST);
    assign w_expect  = 8'(~r_sum + 8'd1);
    assign w_pl_wr   = i_accept && (r_pos >= POS_PAYLOAD0) && (r_pos <= POS_PAYLOAD_N);
    assign w_slot    = SLOT_W'(r_pos - POS_PAYLOAD0);

    always_comb begin
        n_pos       = r_pos;
        n_sum       = r_sum;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            if (w_hunt) begin
                n_pos = POS_HUNT;
                if (i_byte == i_start_tag) begin
                    n_pos = POS_FIRST;
                    n_sum = 8'd0;
                end
            end else if (!o_at_last) begin
                n_sum = r_sum + i_byte;
                n_pos = r_pos + POS_FIRST;
            end else begin
                n_pos       = POS_HUNT;
                n_sum       = 8'd0;
                o_res_valid = 1'b1;
                if (i_byte != w_expect) begin
                    o_res.frame_status = STATUS_BAD;
                end else begin
                    o_res.frame_status = STATUS_GOOD;
                    case (i_mode)
                        MODE_UPLOAD: begin
                            o_res.concentration_ppb = {r_payload[2], r_payload[3]};
                        end
                        MODE_QUERY: begin
                            o_res.concentration_ppb  = {r_payload[4], r_payload[5]};
                            o_res.concentration_ugm3 = {r_payload[0], r_payload[1]};
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
            r_sum <= 8'd0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pl_wr) begin
            r_payload[w_slot] <= i_byte;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("byte position out of range");

    a_last_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_at_last) |=> (r_pos == POS_HUNT && r_sum == 8'd0))
        else $error("no return to hunting after last byte");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_pos == POS_HUNT && i_byte == i_start_tag)
        |=> (r_pos == POS_FIRST && r_sum == 8'd0))
        else $error("start tag not taken");

    a_res_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (i_accept && o_at_last))
        else $error("result outside last byte");

endmodule

>>> rtl/gsfp_out_stage.sv
// Result register for the output channel; holds a request under stall.
// Depends on gsfp_pkg.
module gsfp_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  gsfp_pkg::t_result     i_res,
    input  logic                  i_stall,
    output logic                  o_full_stalled,
    output logic                  o_valid,
    output gsfp_pkg::t_result     o_res
);
    import gsfp_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_result  r_res;

    assign o_full_stalled = r_valid && i_stall;
    assign n_valid        = i_load || o_full_stalled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_load && o_full_stalled))
        else $error("held request overwritten");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_valid && r_res == $past(i_res)))
        else $error("loaded request not presented");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_stall && !i_load) |=> !r_valid)
        else $error("request repeated after being taken");

endmodule

>>> rtl/gas_sensor_frame_parser_top.sv
// Gas sensor frame parser, top level. One received byte per cycle unless o_rx_stall is high.
// Result request is valid in the cycle after the checksum byte is taken.
// Throughput: one byte per cycle; input stalls only on a checksum byte while
// the result register holds a stalled request.
// Reset (synchronous, active low): hunting, sum zero, mode upload, tag 0xFF.
// Depends on gsfp_pkg, gsfp_cfg_regs, gsfp_frame_parser, gsfp_out_stage.
module gas_sensor_frame_parser_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gsfp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_rx_valid,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_rx_stall,
    output logic                          o_res_valid,
    output logic                          o_frame_status,
    output logic [15:0]                   o_concentration_ppb,
    output logic [15:0]                   o_concentration_ugm3,
    input  logic                          i_res_stall
);
    import gsfp_pkg::*;

    t_mode       w_mode;
    logic [7:0]  w_tag;
    logic        w_accept;
    logic        w_at_last;
    logic        w_res_valid;
    t_result     w_res;
    logic        w_full_stalled;
    t_result     w_out;

    assign o_rx_stall = w_full_stalled && w_at_last;
    assign w_accept   = i_rx_valid && !o_rx_stall;

    gsfp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_mode      (w_mode),
        .o_start_tag (w_tag)
    );

    gsfp_frame_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (i_rx_byte),
        .i_mode      (w_mode),
        .i_start_tag (w_tag),
        .o_at_last   (w_at_last),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    gsfp_out_stage u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_res_valid),
        .i_res          (w_res),
        .i_stall        (i_res_stall),
        .o_full_stalled (w_full_stalled),
        .o_valid        (o_res_valid),
        .o_res          (w_out)
    );

    assign o_frame_status       = w_out.frame_status;
    assign o_concentration_ppb  = w_out.concentration_ppb;
    assign o_concentration_ugm3 = w_out.concentration_ugm3;

endmodule
